>>> hw/rtl/vsdb_pkg.sv
// vsdb_pkg: shared codes and control structs of the voxel store with dirty box
// no dependencies; used by vsdb_sweep, vsdb_box_track, the top level and the testbench

package vsdb_pkg;

  // request operation codes
  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  // result status codes
  typedef enum logic [2:0] {
    ST_OUT_OF_BOUNDS = 3'd0,
    ST_UNCHANGED     = 3'd1,
    ST_CHANGED       = 3'd2,
    ST_READ_OK       = 3'd3,
    ST_CLEARED       = 3'd4
  } status_e;

  // fill sweep sequencer states
  typedef enum logic {
    SW_IDLE = 1'b0,
    SW_RUN  = 1'b1
  } sweep_state_e;

  // register index of fill_material, taken from paddr bit 2
  localparam logic REG_FILL_MATERIAL = 1'b0;

  // fill sweep control toward the top level
  typedef struct packed {
    logic busy;
    logic we;
  } sweep_t;

  // dirty box update request
  typedef struct packed {
    logic clear;
    logic grow;
  } box_ctl_t;

endpackage

>>> hw/rtl/voxel_store_dirty_box_unit.sv
// voxel_store_dirty_box_unit: top level of the voxel store with dirty box
// depends on vsdb_pkg, vsdb_cell_ram, vsdb_sweep and vsdb_box_track
//
// usage
//   request channel: operation_i, coord_x/y/z_i, new_material_i; a request is
//   taken at a rising edge with start_i high and busy_o low
//   result channel: read_material_o, status_o and the dirty box, valid for
//   exactly one cycle while result_valid_o is high; the receiver cannot stall
//   config: apb port, fill_material at byte address 0, pready always high
// timing
//   one request per cycle while busy_o is low; the ram read data and the
//   modify stage are registered at the accepting edge, the modify is
//   combinational, then the write back and the result register load together
//   a write followed at once by a request to the same cell is served by
//   forwarding the pending write data past the ram read port
// reset and fill
//   after reset, and after every write of fill_material, a sweep writes the
//   fill material into all EDGE^3 cells, one cell a cycle; busy_o is high for
//   the sweep and requests wait
//   the dirty box resets to empty and is not touched by the sweep

module voxel_store_dirty_box_unit #(
  parameter int EDGE          = 32,
  parameter int MATERIAL_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // request channel
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         operation_i,
  input  logic signed [15:0] coord_x_i,
  input  logic signed [15:0] coord_y_i,
  input  logic signed [15:0] coord_z_i,
  input  logic [15:0]        new_material_i,
  // result channel
  output logic               result_valid_o,
  output logic [15:0]        read_material_o,
  output logic [2:0]         status_o,
  output logic               dirty_valid_o,
  output logic [4:0]         dirty_min_x_o,
  output logic [4:0]         dirty_min_y_o,
  output logic [4:0]         dirty_min_z_o,
  output logic [4:0]         dirty_max_x_o,
  output logic [4:0]         dirty_max_y_o,
  output logic [4:0]         dirty_max_z_o,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int CELLS = EDGE * EDGE * EDGE;
  localparam int CW    = $clog2(EDGE);
  localparam int AW    = $clog2(CELLS);
  localparam int MB    = MATERIAL_BITS;

  // ---------------------------------------------------------------- config
  logic [15:0] fill_q;
  logic        cfg_we;
  logic [31:0] fill_w;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == vsdb_pkg::REG_FILL_MATERIAL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (cfg_we) begin
      fill_q <= pwdata[15:0];
    end
  end

  assign prdata = (paddr[2] == vsdb_pkg::REG_FILL_MATERIAL) ? 32'(fill_q) : '0;
  assign fill_w = 32'(fill_q);

  // ---------------------------------------------------------------- fill sweep
  vsdb_pkg::sweep_t sweep;
  logic [AW-1:0]    sweep_addr;

  vsdb_sweep #(
    .CELLS (CELLS),
    .AW    (AW)
  ) u_sweep (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (cfg_we),
    .ctl_o     (sweep),
    .addr_o    (sweep_addr)
  );

  assign busy_o = sweep.busy;

  // ---------------------------------------------------------------- request decode
  logic               accept;
  logic [2:0][15:0]   coord_in;
  logic [2:0]         axis_ok;
  logic [2:0][CW-1:0] coord_u;
  logic               in_cube;
  logic [AW-1:0]      req_idx;
  logic [31:0]        new_mat_w;

  assign accept   = start_i && !busy_o;
  assign coord_in = {coord_z_i, coord_y_i, coord_x_i};

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      // negative values fail on the sign bit, the rest on the unsigned compare
      axis_ok[a] = !coord_in[a][15] && (coord_in[a] < 16'(EDGE));
      coord_u[a] = coord_in[a][CW-1:0];
    end
  end

  assign in_cube   = &axis_ok;
  // x + EDGE*y + EDGE^2*z; a shift when EDGE is a power of two
  assign req_idx   = AW'(coord_u[0])
                   + AW'(EDGE) * AW'(coord_u[1])
                   + AW'(EDGE * EDGE) * AW'(coord_u[2]);
  assign new_mat_w = 32'(new_material_i);

  // ---------------------------------------------------------------- modify stage
  logic               s1_valid_q;
  logic [1:0]         s1_op_q;
  logic               s1_inside_q;
  logic [AW-1:0]      s1_idx_q;
  logic [MB-1:0]      s1_mat_q;
  logic [2:0][CW-1:0] s1_coord_q;
  logic               fwd_q;
  logic [MB-1:0]      fwd_data_q;

  logic [MB-1:0]      ram_rdata;
  logic [MB-1:0]      old_mat;
  logic               s1_changed;

  assign old_mat    = fwd_q ? fwd_data_q : ram_rdata;
  assign s1_changed = s1_valid_q && (s1_op_q == vsdb_pkg::OP_WRITE) && s1_inside_q
                      && (old_mat != s1_mat_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      // a write landing at this edge is not yet visible to the ram read
      fwd_q      <= accept && s1_changed && (s1_idx_q == req_idx);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q     <= operation_i;
      s1_inside_q <= in_cube;
      s1_idx_q    <= req_idx;
      s1_mat_q    <= new_mat_w[MB-1:0];
      s1_coord_q  <= coord_u;
      fwd_data_q  <= s1_mat_q;
    end
  end

  // ---------------------------------------------------------------- cell memory
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [MB-1:0] ram_wdata;

  // the sweep takes priority on the write port; no request is accepted during a sweep
  assign ram_we    = sweep.we || s1_changed;
  assign ram_waddr = sweep.we ? sweep_addr : s1_idx_q;
  assign ram_wdata = sweep.we ? fill_w[MB-1:0] : s1_mat_q;

  vsdb_cell_ram #(
    .DEPTH (CELLS),
    .AW    (AW),
    .DW    (MB)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (req_idx),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------- dirty box
  vsdb_pkg::box_ctl_t box_ctl;
  logic               box_valid;
  logic [2:0][CW-1:0] box_min;
  logic [2:0][CW-1:0] box_max;

  assign box_ctl.clear = s1_valid_q && (s1_op_q == vsdb_pkg::OP_CLEAR);
  assign box_ctl.grow  = s1_changed;

  vsdb_box_track #(
    .CW (CW)
  ) u_box (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (box_ctl),
    .coord_i (s1_coord_q),
    .valid_o (box_valid),
    .min_o   (box_min),
    .max_o   (box_max)
  );

  // ---------------------------------------------------------------- result
  vsdb_pkg::status_e res_status_q, res_status_d;
  logic [15:0]       res_mat_q, res_mat_d;
  logic              res_valid_q;
  logic [31:0]       old_mat_w;

  assign old_mat_w = 32'(old_mat);

  always_comb begin
    res_status_d = vsdb_pkg::ST_OUT_OF_BOUNDS;
    res_mat_d    = '0;
    case (s1_op_q)
      vsdb_pkg::OP_CLEAR: begin
        res_status_d = vsdb_pkg::ST_CLEARED;
      end
      vsdb_pkg::OP_READ: begin
        if (s1_inside_q) begin
          res_status_d = vsdb_pkg::ST_READ_OK;
          res_mat_d    = old_mat_w[15:0];
        end
      end
      vsdb_pkg::OP_WRITE: begin
        if (s1_inside_q) begin
          res_status_d = s1_changed ? vsdb_pkg::ST_CHANGED : vsdb_pkg::ST_UNCHANGED;
        end
      end
      default: begin
        // unused operation code touches nothing
        res_status_d = vsdb_pkg::ST_OUT_OF_BOUNDS;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      res_status_q <= res_status_d;
      res_mat_q    <= res_mat_d;
    end
  end

  // the box registers hold the post-step box during the strobe cycle
  logic [2:0][31:0] min_w;
  logic [2:0][31:0] max_w;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      min_w[a] = 32'(box_min[a]);
      max_w[a] = 32'(box_max[a]);
    end
  end

  assign result_valid_o  = res_valid_q;
  assign read_material_o = res_mat_q;
  assign status_o        = res_status_q;
  assign dirty_valid_o   = box_valid;
  assign dirty_min_x_o   = min_w[0][4:0];
  assign dirty_min_y_o   = min_w[1][4:0];
  assign dirty_min_z_o   = min_w[2][4:0];
  assign dirty_max_x_o   = max_w[0][4:0];
  assign dirty_max_y_o   = max_w[1][4:0];
  assign dirty_max_z_o   = max_w[2][4:0];

`ifndef SYNTHESIS
  // asserts that no request sits in the modify stage during a sweep write
  a_no_write_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(sweep.we && s1_valid_q))
    else $error("sweep write collides with request write");

  // every request in the modify stage yields one result strobe
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |=> result_valid_o)
    else $error("modify stage lost its result");

  // forwarding only for a request in the modify stage
  a_fwd_in_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> s1_valid_q)
    else $error("forwarding without a request in flight");

  // a changed cell leaves a valid box for the strobe
  a_changed_box: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_changed |=> (dirty_valid_o && (status_o == vsdb_pkg::ST_CHANGED)))
    else $error("changed write without valid dirty box");
`endif

endmodule

>>> hw/rtl/vsdb_cell_ram.sv
// vsdb_cell_ram: single write, single read cell memory, registered read data
// no dependencies

module vsdb_cell_ram #(
  parameter int DEPTH = 32768,
  parameter int AW    = 15,
  parameter int DW    = 16
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  // read before write on the same address
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/vsdb_sweep.sv
// vsdb_sweep: sequencer that rewrites every cell with the fill material
// depends on vsdb_pkg for state and control types

module vsdb_sweep #(
  parameter int CELLS = 32768,
  parameter int AW    = 15
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             restart_i,
  output vsdb_pkg::sweep_t ctl_o,
  output logic [AW-1:0]    addr_o
);

  vsdb_pkg::sweep_state_e state_q, state_d;
  logic [AW-1:0]          addr_q, addr_d;
  logic                   last;

  assign last = (addr_q == AW'(CELLS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vsdb_pkg::SW_RUN;
      addr_q  <= '0;
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    addr_d     = addr_q;
    ctl_o.busy = 1'b0;
    ctl_o.we   = 1'b0;
    case (state_q)
      vsdb_pkg::SW_IDLE: begin
        if (restart_i) begin
          state_d = vsdb_pkg::SW_RUN;
          addr_d  = '0;
        end
      end
      vsdb_pkg::SW_RUN: begin
        ctl_o.busy = 1'b1;
        ctl_o.we   = 1'b1;
        if (restart_i) begin
          addr_d = '0;
        end else if (last) begin
          state_d = vsdb_pkg::SW_IDLE;
          addr_d  = '0;
        end else begin
          addr_d = addr_q + AW'(1);
        end
      end
      default: begin
        state_d = vsdb_pkg::SW_IDLE;
      end
    endcase
  end

  assign addr_o = addr_q;

endmodule

>>> hw/rtl/vsdb_box_track.sv
// vsdb_box_track: min/max bounding box of changed cells
// depends on vsdb_pkg for the update request struct

module vsdb_box_track #(
  parameter int CW = 5
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  vsdb_pkg::box_ctl_t   ctl_i,
  input  logic [2:0][CW-1:0]   coord_i,
  output logic                 valid_o,
  output logic [2:0][CW-1:0]   min_o,
  output logic [2:0][CW-1:0]   max_o
);

  logic               valid_q, valid_d;
  logic [2:0][CW-1:0] min_q, min_d;
  logic [2:0][CW-1:0] max_q, max_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      min_q   <= '0;
      max_q   <= '0;
    end else begin
      valid_q <= valid_d;
      min_q   <= min_d;
      max_q   <= max_d;
    end
  end

  always_comb begin
    valid_d = valid_q;
    min_d   = min_q;
    max_d   = max_q;
    if (ctl_i.clear) begin
      valid_d = 1'b0;
      min_d   = '0;
      max_d   = '0;
    end else if (ctl_i.grow) begin
      valid_d = 1'b1;
      for (int a = 0; a < 3; a++) begin
        // first changed cell seeds the box
        if (!valid_q || (coord_i[a] < min_q[a])) begin
          min_d[a] = coord_i[a];
        end
        if (!valid_q || (coord_i[a] > max_q[a])) begin
          max_d[a] = coord_i[a];
        end
      end
    end
  end

  assign valid_o = valid_q;
  assign min_o   = min_q;
  assign max_o   = max_q;

endmodule

>>> verif/voxel_store_checker.sv
// voxel_store_checker: watches the request, result and apb channels of the voxel store,
// predicts every result from its own copy of the cells and dirty box and compares them
// depends on vsdb_pkg for the operation and status codes

module voxel_store_checker #(
  parameter int EDGE = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic [1:0]         operation_i,
  input  logic signed [15:0] coord_x_i,
  input  logic signed [15:0] coord_y_i,
  input  logic signed [15:0] coord_z_i,
  input  logic [15:0]        new_material_i,
  input  logic               result_valid_i,
  input  logic [15:0]        read_material_i,
  input  logic [2:0]         status_i,
  input  logic               dirty_valid_i,
  input  logic [4:0]         dirty_min_x_i,
  input  logic [4:0]         dirty_min_y_i,
  input  logic [4:0]         dirty_min_z_i,
  input  logic [4:0]         dirty_max_x_i,
  input  logic [4:0]         dirty_max_y_i,
  input  logic [4:0]         dirty_max_z_i,
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic [2:0]         paddr_i,
  input  logic [31:0]        pwdata_i,
  input  logic [31:0]        prdata_i,
  input  logic               pready_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef struct packed {
    logic [15:0]       material;
    vsdb_pkg::status_e status;
    logic              box_valid;
    logic [4:0]        min_x;
    logic [4:0]        min_y;
    logic [4:0]        min_z;
    logic [4:0]        max_x;
    logic [4:0]        max_y;
    logic [4:0]        max_z;
  } voxel_result_t;

  // cells never written since the last sweep hold the fill material
  logic [15:0]   fill_material;
  logic [15:0]   written_cells [int];
  bit            box_on;
  logic [4:0]    box_lo [3];
  logic [4:0]    box_hi [3];
  voxel_result_t pending_results_q [$];
  voxel_result_t want;
  int            failures = 0;

  function automatic voxel_result_t predict_access(input logic [1:0] op,
                                                   input logic signed [15:0] x,
                                                   input logic signed [15:0] y,
                                                   input logic signed [15:0] z,
                                                   input logic [15:0] mat);
    voxel_result_t      res;
    logic signed [15:0] c [3];
    logic [4:0]         pos [3];
    bit                 in_range;
    int                 idx;
    logic [15:0]        held;
    c = '{x, y, z};
    in_range = 1'b1;
    for (int a = 0; a < 3; a++) begin
      if (c[a] < 0 || c[a] >= EDGE) in_range = 1'b0;
      pos[a] = c[a][4:0];
    end
    res = '0;
    res.status = vsdb_pkg::ST_OUT_OF_BOUNDS;
    if (op == vsdb_pkg::OP_CLEAR) begin
      box_on = 1'b0;
      box_lo = '{default: '0};
      box_hi = '{default: '0};
      res.status = vsdb_pkg::ST_CLEARED;
    end else if ((op == vsdb_pkg::OP_READ || op == vsdb_pkg::OP_WRITE) && in_range) begin
      idx = int'(pos[0]) + EDGE * (int'(pos[1]) + EDGE * int'(pos[2]));
      held = written_cells.exists(idx) ? written_cells[idx] : fill_material;
      if (op == vsdb_pkg::OP_READ) begin
        res.material = held;
        res.status = vsdb_pkg::ST_READ_OK;
      end else if (held == mat) begin
        res.status = vsdb_pkg::ST_UNCHANGED;
      end else begin
        written_cells[idx] = mat;
        res.status = vsdb_pkg::ST_CHANGED;
        for (int a = 0; a < 3; a++) begin
          if (!box_on || pos[a] < box_lo[a]) box_lo[a] = pos[a];
          if (!box_on || pos[a] > box_hi[a]) box_hi[a] = pos[a];
        end
        box_on = 1'b1;
      end
    end
    res.box_valid = box_on;
    res.min_x = box_lo[0];
    res.min_y = box_lo[1];
    res.min_z = box_lo[2];
    res.max_x = box_hi[0];
    res.max_y = box_hi[1];
    res.max_z = box_hi[2];
    return res;
  endfunction

  task automatic note_field(input string what, input logic [31:0] exp_v,
                            input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s expected %0h actual %0h", $time, what, exp_v, act_v);
      failures++;
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      fill_material = '0;
      written_cells.delete();
      box_on = 1'b0;
      box_lo = '{default: '0};
      box_hi = '{default: '0};
      pending_results_q.delete();
    end else begin
      if (result_valid_i) begin
        if (pending_results_q.size() == 0) begin
          $display("%0t: result with no request outstanding, status %0h", $time, status_i);
          failures++;
        end else begin
          want = pending_results_q.pop_front();
          note_field("read_material", 32'(want.material), 32'(read_material_i));
          note_field("status", 32'(want.status), 32'(status_i));
          note_field("dirty_valid", 32'(want.box_valid), 32'(dirty_valid_i));
          note_field("dirty_min_x", 32'(want.min_x), 32'(dirty_min_x_i));
          note_field("dirty_min_y", 32'(want.min_y), 32'(dirty_min_y_i));
          note_field("dirty_min_z", 32'(want.min_z), 32'(dirty_min_z_i));
          note_field("dirty_max_x", 32'(want.max_x), 32'(dirty_max_x_i));
          note_field("dirty_max_y", 32'(want.max_y), 32'(dirty_max_y_i));
          note_field("dirty_max_z", 32'(want.max_z), 32'(dirty_max_z_i));
        end
      end
      if (psel_i && penable_i && pready_i) begin
        if (pwrite_i) begin
          // a new fill value sweeps every cell, the box is kept
          if (paddr_i[2] == vsdb_pkg::REG_FILL_MATERIAL) begin
            fill_material = pwdata_i[15:0];
            written_cells.delete();
          end
        end else begin
          note_field("fill_material readback", {16'b0, fill_material}, prdata_i);
        end
      end
      if (start_i && !busy_i) begin
        pending_results_q.push_back(predict_access(operation_i, coord_x_i, coord_y_i,
                                                   coord_z_i, new_material_i));
      end
    end
    pending_o    <= pending_results_q.size();
    fail_count_o <= failures;
  end

endmodule

>>> verif/tb_top.sv
// tb_top: stimulus and verdict for voxel_store_dirty_box_unit
// depends on vsdb_pkg, the unit itself and voxel_store_checker, which does all checking

module tb_top;

  localparam int EDGE = 32;
  // operation code the block has no use for, it must be ignored
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // fill_material lives at byte address 0
  localparam logic [2:0] FILL_ADDR = {vsdb_pkg::REG_FILL_MATERIAL, 2'b00};

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               start_i        = 1'b0;
  logic               busy_o;
  logic [1:0]         operation_i    = vsdb_pkg::OP_READ;
  logic signed [15:0] coord_x_i      = '0;
  logic signed [15:0] coord_y_i      = '0;
  logic signed [15:0] coord_z_i      = '0;
  logic [15:0]        new_material_i = '0;
  logic               result_valid_o;
  logic [15:0]        read_material_o;
  logic [2:0]         status_o;
  logic               dirty_valid_o;
  logic [4:0]         dirty_min_x_o, dirty_min_y_o, dirty_min_z_o;
  logic [4:0]         dirty_max_x_o, dirty_max_y_o, dirty_max_z_o;
  logic               psel           = 1'b0;
  logic               penable        = 1'b0;
  logic               pwrite         = 1'b0;
  logic [2:0]         paddr          = '0;
  logic [31:0]        pwdata         = '0;
  logic [31:0]        prdata;
  logic               pready;

  int          fail_count;
  int          pending;
  int          burst_left = 0;
  // fill value last written, used to aim writes at cells that already hold it
  logic [15:0] fill_now   = '0;

  // 2 time unit clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  voxel_store_dirty_box_unit #(
    .EDGE          (EDGE),
    .MATERIAL_BITS (16)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .operation_i     (operation_i),
    .coord_x_i       (coord_x_i),
    .coord_y_i       (coord_y_i),
    .coord_z_i       (coord_z_i),
    .new_material_i  (new_material_i),
    .result_valid_o  (result_valid_o),
    .read_material_o (read_material_o),
    .status_o        (status_o),
    .dirty_valid_o   (dirty_valid_o),
    .dirty_min_x_o   (dirty_min_x_o),
    .dirty_min_y_o   (dirty_min_y_o),
    .dirty_min_z_o   (dirty_min_z_o),
    .dirty_max_x_o   (dirty_max_x_o),
    .dirty_max_y_o   (dirty_max_y_o),
    .dirty_max_z_o   (dirty_max_z_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  voxel_store_checker #(
    .EDGE (EDGE)
  ) u_store_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_i          (busy_o),
    .operation_i     (operation_i),
    .coord_x_i       (coord_x_i),
    .coord_y_i       (coord_y_i),
    .coord_z_i       (coord_z_i),
    .new_material_i  (new_material_i),
    .result_valid_i  (result_valid_o),
    .read_material_i (read_material_o),
    .status_i        (status_o),
    .dirty_valid_i   (dirty_valid_o),
    .dirty_min_x_i   (dirty_min_x_o),
    .dirty_min_y_i   (dirty_min_y_o),
    .dirty_min_z_i   (dirty_min_z_o),
    .dirty_max_x_i   (dirty_max_x_o),
    .dirty_max_y_i   (dirty_max_y_o),
    .dirty_max_z_i   (dirty_max_z_o),
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .prdata_i        (prdata),
    .pready_i        (pready),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  // coordinate inside the cube, a third of them packed into a small corner
  // so that reads and rewrites hit cells written before
  function automatic logic signed [15:0] coord_in_range();
    if ($urandom_range(0, 2) == 0) return 16'($urandom_range(0, 3));
    return 16'($urandom_range(0, EDGE - 1));
  endfunction

  // coordinate for noise requests: edges of the signed range, just outside
  // the cube, fully random bits, or plain in range
  function automatic logic signed [15:0] coord_any();
    case ($urandom_range(0, 3))
      0: return 16'($urandom());
      1: begin
        case ($urandom_range(0, 3))
          0: return -16'sd1;
          1: return 16'(EDGE);
          2: return -16'sd32768;
          default: return 16'sd32767;
        endcase
      end
      default: return coord_in_range();
    endcase
  endfunction

  // materials: the fill value (no change on a fresh cell), a few small values
  // that repeat, fully random bits, or an extreme
  function automatic logic [15:0] pick_material();
    case ($urandom_range(0, 3))
      0: return fill_now;
      1: return 16'($urandom_range(0, 3));
      2: return 16'($urandom());
      default: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    endcase
  endfunction

  // one request: maybe a random gap first, then hold start until busy is low
  // at a rising edge; start stays high afterwards so bursts run back to back
  task automatic send_request(input logic [1:0] op, input logic signed [15:0] x,
                              input logic signed [15:0] y, input logic signed [15:0] z,
                              input logic [15:0] mat);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        start_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      // now and then a long stretch with no idling at all
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 16);
    end
    start_i        <= 1'b1;
    operation_i    <= op;
    coord_x_i      <= x;
    coord_y_i      <= y;
    coord_z_i      <= z;
    new_material_i <= mat;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    burst_left--;
  endtask

  // mostly well-formed accesses inside the cube, with write/read pairs and
  // repeated writes to the same cell, plus clears and some noise
  task automatic random_requests(input int count);
    int                 left;
    logic signed [15:0] x, y, z;
    logic [15:0]        mat;
    left = count;
    while (left > 0) begin
      x   = coord_in_range();
      y   = coord_in_range();
      z   = coord_in_range();
      mat = pick_material();
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          send_request($urandom_range(0, 1) ? vsdb_pkg::OP_WRITE : vsdb_pkg::OP_READ,
                       x, y, z, mat);
          left--;
        end
        5, 6: begin
          // write then read back the same cell, exercises forwarding when back to back
          send_request(vsdb_pkg::OP_WRITE, x, y, z, mat);
          send_request(vsdb_pkg::OP_READ, x, y, z, pick_material());
          left -= 2;
        end
        7: begin
          send_request(vsdb_pkg::OP_CLEAR, 16'($urandom()), 16'($urandom()),
                       16'($urandom()), 16'($urandom()));
          left--;
        end
        8: begin
          // noise: any operation code, coordinates often out of the cube
          send_request(2'($urandom()), coord_any(), coord_any(), coord_any(), mat);
          left--;
        end
        default: begin
          // same value twice, the second write must report unchanged
          send_request(vsdb_pkg::OP_WRITE, x, y, z, mat);
          send_request(vsdb_pkg::OP_WRITE, x, y, z, mat);
          left -= 2;
        end
      endcase
    end
  endtask

  // wait until every result has come back; the extra edge lets the checker
  // count a request accepted at the current edge
  task automatic wait_drained();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // apb setup and access phases; pready ends the access
  task automatic apb_access(input logic write, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= FILL_ADDR;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // new fill value, read back at once; the write starts a full sweep that
  // keeps busy high, so requests afterwards simply wait on busy
  task automatic set_fill(input logic [15:0] value);
    apb_access(1'b1, {16'b0, value});
    @(posedge clk_i);
    apb_access(1'b0, '0);
    fill_now = value;
  endtask

  initial begin
    logic [15:0] fills [3];
    fills = '{16'hFFFF, 16'($urandom()), 16'h0000};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed requests on the reset fill of 0, the start-up sweep runs first
    send_request(vsdb_pkg::OP_READ, 0, 0, 0, 16'h0000);
    send_request(vsdb_pkg::OP_READ, 31, 31, 31, 16'hFFFF);
    send_request(vsdb_pkg::OP_WRITE, 0, 0, 0, 16'hFFFF);      // changed, box opens on one cell
    send_request(vsdb_pkg::OP_WRITE, 0, 0, 0, 16'hFFFF);      // same value again
    send_request(vsdb_pkg::OP_READ, 0, 0, 0, 16'h0000);
    send_request(vsdb_pkg::OP_WRITE, 31, 31, 31, 16'h8001);   // box spans the whole cube
    send_request(vsdb_pkg::OP_READ, 31, 31, 31, 16'h0000);
    send_request(vsdb_pkg::OP_WRITE, 31, 0, 17, 16'h0000);    // fill value on a fresh cell
    send_request(vsdb_pkg::OP_READ, -1, 0, 0, 16'h0000);       // out of the cube on each axis
    send_request(vsdb_pkg::OP_READ, 0, EDGE, 0, 16'h0000);
    send_request(vsdb_pkg::OP_READ, 0, 0, -32768, 16'h0000);
    send_request(vsdb_pkg::OP_READ, 32767, 0, 0, 16'h0000);
    send_request(vsdb_pkg::OP_WRITE, -1, 5, 5, 16'h5555);
    send_request(vsdb_pkg::OP_WRITE, 5, 5, EDGE, 16'h5555);
    send_request(OP_UNUSED, 3, 3, 3, 16'h0001);                // ignored code
    send_request(vsdb_pkg::OP_CLEAR, 16'($urandom()), 16'($urandom()), 16'($urandom()),
                 16'($urandom()));
    send_request(vsdb_pkg::OP_READ, 0, 0, 0, 16'h0000);       // a clear keeps the cells
    send_request(vsdb_pkg::OP_WRITE, 5, 6, 7, 16'h00FF);      // box restarts on this cell
    send_request(vsdb_pkg::OP_WRITE, 2, 9, 30, 16'hA5A5);     // grows down in x, up in y and z
    send_request(vsdb_pkg::OP_CLEAR, 0, 0, 0, 16'h0000);
    send_request(vsdb_pkg::OP_CLEAR, -1, EDGE, 32767, 16'hFFFF); // clear on an empty box
    send_request(vsdb_pkg::OP_WRITE, 31, 31, 31, 16'h8001);   // unchanged leaves box empty
    random_requests(230);

    // further fill settings, each one sweeps the cells while the box is kept
    foreach (fills[i]) begin
      wait_drained();
      repeat (4) @(posedge clk_i);
      set_fill(fills[i]);
      @(posedge clk_i);
      send_request(vsdb_pkg::OP_READ, 16'($urandom_range(0, EDGE - 1)), 0, EDGE - 1,
                   16'h0000);
      random_requests(165);
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // four full sweeps plus the requests must fit within this time limit
  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/vsdb_pkg.sv
hw/rtl/vsdb_cell_ram.sv
hw/rtl/vsdb_sweep.sv
hw/rtl/vsdb_box_track.sv
hw/rtl/voxel_store_dirty_box_unit.sv
verif/voxel_store_checker.sv
verif/tb_top.sv
